@@ design/sha256_pkg.sv @@
// shared types and constants for the sha-256 stream hasher
package sha256_pkg;

    typedef enum logic [1:0] {
        OP_ABSORB  = 2'd0,
        OP_FINISH  = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic        init;        // reload chain, clear counters
        logic        wr_byte;     // write wr_data at wr_addr
        logic [5:0]  wr_addr;
        logic [7:0]  wr_data;
        logic        count_byte;  // bump message length
        logic        load_work;   // chain into working regs, round counter zero
        logic        round;       // one compression round
        logic        fold;        // add working regs into chain
        logic [4:0]  out_idx;
    } t_cmd;

    typedef struct packed {
        logic        round_last;
        logic [63:0] bit_len;
        logic [7:0]  out_byte;
    } t_status;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

@@ design/sha256_stream_hasher_core.sv @@
// sha-256 stream hasher top level
// slave channel: one item per message byte or command; tuser carries the
// opcode (absorb, finish, restart), tdata the message byte.
// master channel: 32 digest bytes per finish, most significant first; tdata
// holds the byte then its index, tlast marks the final byte.
// an absorb writes one message byte; every 64th byte starts the compression,
// which runs one round per cycle in the shared round unit before the next
// item is taken.
// finish writes the pad, zero fill and length one byte per cycle into the
// block buffer, compressing once or twice, then presents the digest one
// byte per cycle while the receiver is ready.
// a repeated finish re-sends the stored digest without compression.
// the block takes no input item while it pads, compresses or emits; when the
// receiver holds m_axis_tready low the current digest byte is held.
// reset reloads the initial hash values and clears length and done state,
// no clearing pass is needed.
module sha256_stream_hasher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // digest_byte, byte_index, zero fill
    output logic        m_axis_tlast    // last
);
    import sha256_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic [4:0] idx;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .o_valid     (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_index     (idx),
        .o_last      (m_axis_tlast),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    sha256_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status)
    );

    assign m_axis_tdata = {3'b000, idx, status.out_byte};

endmodule

@@ design/sha256_datapath.sv @@
// message buffer, schedule window, round unit and chaining value
module sha256_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha256_pkg::t_cmd     i_cmd,
    output sha256_pkg::t_status  o_status
);
    import sha256_pkg::*;

    logic [31:0] r_chain [8];
    logic [31:0] r_w [16];
    logic [31:0] r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [5:0]  r_round;
    logic [63:0] r_len;

    logic [31:0] w_cur, w_new, s0, s1, t1, t2;
    logic [31:0] x, y;
    logic [31:0] out_word;
    logic [4:0]  widx;

    assign w_cur = r_w[0];
    assign x  = r_w[1];
    assign y  = r_w[14];
    assign w_new = r_w[0] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + r_w[9]
                 + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
    assign s1 = rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25);
    assign s0 = rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22);
    assign t1 = r_h + s1 + ((r_e & r_f) ^ (~r_e & r_g)) + ROUND_K[r_round] + w_cur;
    assign t2 = s0 + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));

    assign out_word = r_chain[i_cmd.out_idx[4:2]];
    assign widx = 5'd0;

    always_comb begin
        o_status.round_last = (r_round == 6'd63);
        o_status.bit_len    = {r_len[60:0], 3'b000};
        case (i_cmd.out_idx[1:0])
            2'd0:    o_status.out_byte = out_word[31:24];
            2'd1:    o_status.out_byte = out_word[23:16];
            2'd2:    o_status.out_byte = out_word[15:8];
            default: o_status.out_byte = out_word[7:0];
        endcase
    end

    // message bytes land directly in the schedule window, big-endian per word
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            case (i_cmd.wr_addr[1:0])
                2'd0:    r_w[i_cmd.wr_addr[5:2]][31:24] <= i_cmd.wr_data;
                2'd1:    r_w[i_cmd.wr_addr[5:2]][23:16] <= i_cmd.wr_data;
                2'd2:    r_w[i_cmd.wr_addr[5:2]][15:8]  <= i_cmd.wr_data;
                default: r_w[i_cmd.wr_addr[5:2]][7:0]   <= i_cmd.wr_data;
            endcase
        end else if (i_cmd.load_work) begin
            r_a <= r_chain[0]; r_b <= r_chain[1]; r_c <= r_chain[2]; r_d <= r_chain[3];
            r_e <= r_chain[4]; r_f <= r_chain[5]; r_g <= r_chain[6]; r_h <= r_chain[7];
            r_round <= 6'd0;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
            r_round <= r_round + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.init) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= INIT_H[i];
            end
            r_len <= 64'd0;
        end else begin
            if (i_cmd.count_byte) begin
                r_len <= r_len + 64'd1 + {59'd0, widx};
            end
            if (i_cmd.fold) begin
                r_chain[0] <= r_chain[0] + r_a; r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c; r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e; r_chain[5] <= r_chain[5] + r_f;
                r_chain[6] <= r_chain[6] + r_g; r_chain[7] <= r_chain[7] + r_h;
            end
        end
    end

endmodule

@@ design/sha256_ctrl.sv @@
// controller for intake, padding, compression and digest output
module sha256_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_opcode,
    input  logic [7:0]           i_data,
    output logic                 o_valid,
    input  logic                 i_out_ready,
    output logic [4:0]           o_index,
    output logic                 o_last,
    output sha256_pkg::t_cmd     o_cmd,
    input  sha256_pkg::t_status  i_status
);
    import sha256_pkg::*;

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic        r_done, n_done;
    logic        r_final, n_final;   // compression is the closing one
    logic        r_pad, n_pad;       // padding in progress
    logic [2:0]  r_lcnt, n_lcnt;
    logic [4:0]  r_idx, n_idx;
    logic [63:0] r_bits, n_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= 6'd0;
            r_done  <= 1'b0;
            r_final <= 1'b0;
            r_pad   <= 1'b0;
            r_lcnt  <= 3'd0;
            r_idx   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_done  <= n_done;
            r_final <= n_final;
            r_pad   <= n_pad;
            r_lcnt  <= n_lcnt;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_EMIT);
    assign o_index = r_idx;
    assign o_last  = (r_idx == 5'd31);

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_done  = r_done;
        n_final = r_final;
        n_pad   = r_pad;
        n_lcnt  = r_lcnt;
        n_idx   = r_idx;
        n_bits  = r_bits;
        o_cmd   = '0;
        o_cmd.out_idx = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_opcode)
                        OP_ABSORB: begin
                            if (!r_done) begin
                                o_cmd.wr_byte    = 1'b1;
                                o_cmd.wr_addr    = r_fill;
                                o_cmd.wr_data    = i_data;
                                o_cmd.count_byte = 1'b1;
                                n_fill = r_fill + 6'd1;
                                if (r_fill == 6'd63) begin
                                    n_final = 1'b0;
                                    n_state = ST_LOAD;
                                end
                            end
                        end
                        OP_FINISH: begin
                            n_idx = 5'd0;
                            if (r_done) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_bits  = i_status.bit_len;
                                n_pad   = 1'b1;
                                n_state = ST_PAD_MARK;
                            end
                        end
                        OP_RESTART: begin
                            o_cmd.init = 1'b1;
                            n_fill = 6'd0;
                            n_done = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PAD_MARK: begin
                o_cmd.wr_byte = 1'b1;
                o_cmd.wr_addr = r_fill;
                o_cmd.wr_data = PAD_BYTE;
                n_fill  = r_fill + 6'd1;
                n_state = ST_PAD_ZERO;
                if (r_fill == 6'd63) begin
                    n_final = 1'b0;
                    n_state = ST_LOAD;
                end
            end
            ST_PAD_ZERO: begin
                if (r_fill > LEN_POS) begin
                    o_cmd.wr_byte = 1'b1;
                    o_cmd.wr_addr = r_fill;
                    n_fill = r_fill + 6'd1;
                    if (r_fill == 6'd63) begin
                        n_final = 1'b0;
                        n_state = ST_LOAD;
                    end
                end else if (r_fill < LEN_POS) begin
                    o_cmd.wr_byte = 1'b1;
                    o_cmd.wr_addr = r_fill;
                    n_fill = r_fill + 6'd1;
                end else begin
                    n_lcnt  = 3'd0;
                    n_state = ST_PAD_LEN;
                end
            end
            ST_PAD_LEN: begin
                o_cmd.wr_byte = 1'b1;
                o_cmd.wr_addr = r_fill;
                o_cmd.wr_data = r_bits[63:56];
                n_bits = {r_bits[55:0], 8'd0};
                n_fill = r_fill + 6'd1;
                n_lcnt = r_lcnt + 3'd1;
                if (r_lcnt == 3'd7) begin
                    n_final = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load_work = 1'b1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.round_last) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_final) begin
                    n_done  = 1'b1;
                    n_pad   = 1'b0;
                    n_fill  = 6'd0;
                    n_state = ST_EMIT;
                end else if (r_pad) begin
                    n_state = ST_PAD_ZERO;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 5'd1;
                    if (r_idx == 5'd31) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ design/sha256_checker.sv @@
// port checker for the sha-256 stream hasher
module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[12:8] == 5'd31)))
        else $error("tlast does not match byte index");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken during digest output");

    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tdata[12:8] == $past(m_axis_tdata[12:8]) + 5'd1))
        else $error("digest bytes not consecutive");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled item changed");
endmodule

bind sha256_stream_hasher_core sha256_checker u_chk (.*);

@@ tb/tb_top.sv @@
// self-checking testbench for the sha-256 stream hasher core
`timescale 1ns / 1ps

class digest_scoreboard;
    logic [31:0] chain[8];
    logic [7:0]  blk[64];
    logic [5:0]  fill;
    logic [63:0] total_len;
    bit          done;
    logic [7:0]  exp_byte[$];
    logic [4:0]  exp_idx[$];
    bit          exp_last[$];
    int          errors;

    function new();
        errors = 0;
        restart();
    endfunction

    function void restart();
        for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::INIT_H[i];
        fill = 0;
        total_len = 0;
        done = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + sha256_pkg::ROUND_K[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] data);
        logic [63:0] bits;
        int          k;
        logic [31:0] word;
        if (op == sha256_pkg::OP_ABSORB) begin
            if (done) return;
            blk[fill] = data;
            total_len += 1;
            fill += 1;
            if (fill == 0) compress();
        end else if (op == sha256_pkg::OP_RESTART) begin
            restart();
        end else if (op == sha256_pkg::OP_FINISH) begin
            if (!done) begin
                bits = total_len << 3;
                k = fill;
                blk[k] = sha256_pkg::PAD_BYTE;
                k++;
                if (k > 56) begin
                    for (int i = k; i < 64; i++) blk[i] = 0;
                    compress();
                    k = 0;
                end
                for (int i = k; i < 56; i++) blk[i] = 0;
                for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
                compress();
                fill = 0;
                done = 1;
            end
            for (k = 0; k < 32; k++) begin
                word = chain[k >> 2];
                exp_byte.push_back(8'(word >> (24 - 8 * (k & 3))));
                exp_idx.push_back(k[4:0]);
                exp_last.push_back(k == 31);
            end
        end
    endfunction

    function void check_result(logic [15:0] tdata, logic tlast);
        logic [7:0] eb;
        logic [4:0] ei;
        bit         el;
        if (exp_byte.size() == 0) begin
            $display("%0t unexpected digest byte %h last %b", $time, tdata, tlast);
            errors++;
            return;
        end
        eb = exp_byte.pop_front();
        ei = exp_idx.pop_front();
        el = exp_last.pop_front();
        if (tdata[7:0] !== eb) begin
            $display("%0t digest_byte exp %h got %h", $time, eb, tdata[7:0]);
            errors++;
        end
        if (tdata[12:8] !== ei) begin
            $display("%0t byte_index exp %0d got %0d", $time, ei, tdata[12:8]);
            errors++;
        end
        if (tdata[15:13] !== 3'b0) begin
            $display("%0t fill bits exp 0 got %b", $time, tdata[15:13]);
            errors++;
        end
        if (tlast !== el) begin
            $display("%0t last exp %b got %b", $time, el, tlast);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import sha256_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic [1:0]  s_axis_tuser;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // digest_byte, byte_index, zero fill
    logic        m_axis_tlast;

    digest_scoreboard sb;
    bit  long_hold;
    int  idle_cycles;

    sha256_stream_hasher_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // sends one item and waits for its handshake
    task automatic send_item(logic [1:0] op, logic [7:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, data);
    endtask

    task automatic sender_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_message(int len, bit gaps);
        for (int i = 0; i < len; i++) begin
            send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
            if (gaps) sender_gap();
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.exp_byte.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall pattern, with one long hold-off
    initial begin
        int mode;
        m_axis_tready = 1'b0;
        mode = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            if ($urandom_range(0, 31) == 0) mode = $urandom_range(0, 2);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("sha256_stream_hasher_core regression: fail");
            $finish;
        end
    end

    initial begin
        int sent;
        int r;
        int pad_len[3];
        sb = new();
        long_hold = 0;
        idle_cycles = 0;
        pad_len = '{55, 56, 64};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = OP_ABSORB;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, repeated finish, ignored absorb, opcode three
        send_item(OP_FINISH, 8'h00);
        send_item(OP_FINISH, 8'hff);
        send_item(OP_ABSORB, 8'hff);
        send_item(2'd3, 8'haa);
        send_item(OP_RESTART, 8'h55);
        send_item(OP_ABSORB, 8'h00);
        send_item(OP_ABSORB, 8'hff);
        send_item(2'd3, 8'h12);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_RESTART, 8'h00);
        drain();

        // long receiver hold-off while the sender keeps offering
        long_hold = 1;
        send_message(3, 0);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_RESTART, 8'h00);
        drain();

        // pad boundaries: 55, 56 and 64 bytes
        sent = 0;
        foreach (pad_len[i]) begin
            send_message(pad_len[i], 1);
            send_item(OP_FINISH, 8'h00);
            send_item(OP_RESTART, 8'h00);
            sent += pad_len[i] + 2;
        end
        drain();

        while (sent < 420) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                r = $urandom_range(0, 3) == 0 ? $urandom_range(50, 70) : $urandom_range(0, 12);
                send_message(r, 1);
                send_item(OP_FINISH, 8'h00);
                if ($urandom_range(0, 3) == 0) send_item(OP_FINISH, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 3) == 0) send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
                send_item(OP_RESTART, 8'($urandom_range(0, 255)));
                sent += r + 2;
            end else begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                sent++;
            end
            sender_gap();
        end
        send_item(OP_FINISH, 8'h00);
        drain();
        repeat (250) @(posedge i_clk);
        if (sb.errors == 0 && sb.exp_byte.size() == 0)
            $display("sha256_stream_hasher_core regression: pass");
        else
            $display("sha256_stream_hasher_core regression: fail");
        $finish;
    end
endmodule
